// ===== rtl/smmas_pkg.sv =====
// Shared types and constants for the small matrix multiply/add/subtract block.
`timescale 1ns / 1ps
package smmas_pkg;

  localparam int MAX_DIM_DEF = 8;   // default largest matrix dimension
  localparam int STRIDE      = 8;   // entries per row in the element stores

  localparam int OP_W    = 3;
  localparam int IDX_W   = 3;
  localparam int ELEM_W  = 16;
  localparam int RES_W   = 35;
  localparam int DIM_W   = 4;
  localparam int REG_W   = 2;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [RES_W-1:0]   res_t;
  typedef logic [DIM_W-1:0]          dim_t;
  typedef logic [REG_W-1:0]          reg_idx_t;

  // Commands
  localparam op_t OP_WR_A = 3'd0;
  localparam op_t OP_WR_B = 3'd1;
  localparam op_t OP_MUL  = 3'd2;
  localparam op_t OP_ADD  = 3'd3;
  localparam op_t OP_SUB  = 3'd4;

  // Configuration register indexes
  localparam reg_idx_t REG_A_ROWS = 2'd0;
  localparam reg_idx_t REG_A_COLS = 2'd1;
  localparam reg_idx_t REG_B_ROWS = 2'd2;
  localparam reg_idx_t REG_B_COLS = 2'd3;

endpackage

// ===== rtl/smmas_if.sv =====
// Channel interfaces: command input, result output and configuration write.
`timescale 1ns / 1ps
interface smmas_in_if import smmas_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   op;
  idx_t  row;
  idx_t  col;
  elem_t value;

  modport source (output valid, output op, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input op, input row, input col, input value,
                  output ready);
endinterface

interface smmas_out_if import smmas_pkg::*; ();
  logic valid;
  logic ready;
  idx_t out_row;
  idx_t out_col;
  res_t result_value;
  logic last;

  modport source (output valid, output out_row, output out_col, output result_value,
                  output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input result_value,
                  input last, output ready);
endinterface

interface smmas_cfg_if import smmas_pkg::*; ();
  logic     valid;
  logic     ready;
  reg_idx_t index;
  dim_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/small_matrix_multiply_add_sub.sv =====
// Top level: matrix stores, command sequencer, MAC pipeline and result register.
`timescale 1ns / 1ps
// Element writes (op 0/1) take one beat per cycle while no compute command runs.
// A compute command is accepted and then holds the input off while it runs:
// each result element reads K operand pairs, with K = a_cols for multiply and
// K = 1 for add/subtract, and its terms pass the read, term and accumulate
// registers before the element is handed to the result register. A multiply
// with a_cols zero skips the reads and hands off a zero sum. Throughput is set
// by the single read port of each element store, which delivers one A and one
// B operand per cycle, while reading, to one multiplier and one accumulator.
// Results are held in an output register, so the next element is computed while
// the previous one waits to be taken. The stores read as zero after reset; no
// clearing pass is needed.
module small_matrix_multiply_add_sub
  import smmas_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  smmas_in_if.sink     in_if,
  smmas_out_if.source  out_if,
  smmas_cfg_if.sink    cfg_if
);

  localparam int DEPTH = MAX_DIM * STRIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam dim_t DMAX = DIM_W'(MAX_DIM);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  // configuration
  dim_t a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  dim_t ar, ac, br, bc;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= '0;
      a_cols_r <= '0;
      b_rows_r <= '0;
      b_cols_r <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_A_ROWS: a_rows_r <= cfg_if.data;
        REG_A_COLS: a_cols_r <= cfg_if.data;
        REG_B_ROWS: b_rows_r <= cfg_if.data;
        REG_B_COLS: b_cols_r <= cfg_if.data;
      endcase
    end
  end

  assign ar = (a_rows_r > DMAX) ? DMAX : a_rows_r;
  assign ac = (a_cols_r > DMAX) ? DMAX : a_cols_r;
  assign br = (b_rows_r > DMAX) ? DMAX : b_rows_r;
  assign bc = (b_cols_r > DMAX) ? DMAX : b_cols_r;

  // sequencer state
  logic [1:0] state_r, state_nxt;
  idx_t       i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  dim_t       rows_r, cols_r, kn_r;
  logic       mul_r, sub_r;

  logic in_acc;
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  // command decode
  logic cmd_go;
  dim_t cmd_rows, cmd_cols, cmd_kn;

  always_comb begin
    cmd_go   = 1'b0;
    cmd_rows = ar;
    cmd_cols = bc;
    cmd_kn   = ac;
    unique case (in_if.op) inside
      OP_MUL: begin
        cmd_go = (ac == br) && (ar != '0) && (bc != '0);
      end
      OP_ADD, OP_SUB: begin
        cmd_cols = ac;
        cmd_kn   = DIM_W'(1);
        cmd_go   = (ar == br) && (ac == bc) && (ar != '0) && (ac != '0);
      end
      default: cmd_go = 1'b0;
    endcase
  end

  // element stores
  logic [AW-1:0]    a_raddr, b_raddr, waddr;
  logic [5:0]       a_raddr6, b_raddr6, waddr6;
  logic             wr_ok, wr_a, wr_b, rd_en;
  elem_t            mem_a [DEPTH];
  elem_t            mem_b [DEPTH];
  logic [DEPTH-1:0] a_vld_r, b_vld_r;
  elem_t            a_q_r, b_q_r;
  logic             a_ok_r, b_ok_r;

  assign waddr6 = {in_if.row, in_if.col};
  assign waddr  = waddr6[AW-1:0];
  assign wr_ok  = ({1'b0, in_if.row} < DMAX) && ({1'b0, in_if.col} < DMAX);
  assign wr_a   = in_acc && (in_if.op == OP_WR_A) && wr_ok;
  assign wr_b   = in_acc && (in_if.op == OP_WR_B) && wr_ok;

  assign a_raddr6 = mul_r ? {i_r, k_r} : {i_r, j_r};
  assign b_raddr6 = mul_r ? {k_r, j_r} : {i_r, j_r};
  assign a_raddr  = a_raddr6[AW-1:0];
  assign b_raddr  = b_raddr6[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_a) mem_a[waddr] <= in_if.value;
    if (wr_b) mem_b[waddr] <= in_if.value;
    if (rd_en) begin
      a_q_r <= mem_a[a_raddr];
      b_q_r <= mem_b[b_raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      b_vld_r <= '0;
    end else begin
      if (wr_a) a_vld_r[waddr] <= 1'b1;
      if (wr_b) b_vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_ok_r <= a_vld_r[a_raddr];
      b_ok_r <= b_vld_r[b_raddr];
    end
  end

  // MAC pipeline: read -> term -> accumulate
  logic         k_last, k_zero;
  logic         s1_vld_r, s1_first_r, s1_last_r;
  logic         s2_vld_r, s2_first_r, s2_last_r;
  elem_t        a_op, b_op;
  logic signed [31:0] prod, term_r;
  logic signed [16:0] sum;
  res_t         acc_r;
  logic         acc_done_r;

  assign k_last = ({1'b0, k_r} + DIM_W'(1)) == kn_r;
  assign k_zero = (kn_r == '0);
  assign rd_en  = (state_r == S_RD) && !k_zero;

  assign a_op = a_ok_r ? a_q_r : '0;
  assign b_op = b_ok_r ? b_q_r : '0;
  assign prod = a_op * b_op;
  assign sum  = sub_r ? ({a_op[15], a_op} - {b_op[15], b_op})
                      : ({a_op[15], a_op} + {b_op[15], b_op});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= rd_en;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_first_r <= (k_r == '0);
      s1_last_r  <= k_last;
    end
    if (s1_vld_r) begin
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      term_r     <= mul_r ? prod : {{7{sum[16]}}, sum, 8'h00};
    end
  end

  logic out_load, fin, i_last, j_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_done_r <= 1'b0;
    end else if (state_r == S_RD && k_zero) begin
      acc_done_r <= 1'b1;
    end else if (s2_vld_r && s2_last_r) begin
      acc_done_r <= 1'b1;
    end else if (out_load) begin
      acc_done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD && k_zero) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= s2_first_r ? RES_W'(term_r) : acc_r + RES_W'(term_r);
    end
  end

  // sequencer
  assign j_last   = ({1'b0, j_r} + DIM_W'(1)) == cols_r;
  assign i_last   = ({1'b0, i_r} + DIM_W'(1)) == rows_r;
  assign fin      = i_last && j_last;
  assign out_load = (state_r == S_WAIT) && acc_done_r && (!out_if.valid || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && cmd_go) begin
          state_nxt = S_RD;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      S_RD: begin
        if (k_zero || k_last) begin
          state_nxt = S_WAIT;
          k_nxt     = '0;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (out_load) begin
          if (fin) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
            if (j_last) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && cmd_go) begin
      rows_r <= cmd_rows;
      cols_r <= cmd_cols;
      kn_r   <= cmd_kn;
      mul_r  <= (in_if.op == OP_MUL);
      sub_r  <= (in_if.op == OP_SUB);
    end
  end

  // result register
  logic out_valid_r;
  idx_t out_row_r, out_col_r;
  res_t out_val_r;
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= i_r;
      out_col_r  <= j_r;
      out_val_r  <= acc_r;
      out_last_r <= fin;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.out_row      = out_row_r;
  assign out_if.out_col      = out_col_r;
  assign out_if.result_value = out_val_r;
  assign out_if.last         = out_last_r;

`ifndef NO_ASSERTIONS
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_a || wr_b) |-> (state_r == S_IDLE))
    else $error("store written while a command runs");

  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r || s2_vld_r) |-> (state_r == S_RD || state_r == S_WAIT))
    else $error("MAC pipeline active outside a command");

  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |=> s2_vld_r)
    else $error("term lost between read and accumulate");

  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(acc_done_r) |-> ($past(s2_vld_r) || $past(state_r == S_RD)))
    else $error("element finished without a term or an empty sum");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !acc_done_r)
    else $error("finished element not consumed on hand-off");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the matrix multiply/add/subtract block.
`timescale 1ns / 1ps
module tb_top;
  import smmas_pkg::*;

  localparam int MAX_DIM     = MAX_DIM_DEF;
  localparam int IDLE_GAP    = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 16;
  localparam int PHASE_ITEMS = 25;
  localparam int PRESS_PHASE = 4;
  localparam op_t OP_UNUSED_LO = OP_SUB + 3'd1;
  localparam op_t OP_UNUSED_HI = '1;

  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_ONE} check_t;
  typedef enum logic {ST_CMD, ST_REG} step_kind_t;

  typedef struct {
    step_kind_t kind;
    op_t        op;
    idx_t       row;
    idx_t       col;
    elem_t      value;
    reg_idx_t   sel;
    dim_t       data;
    check_t     chk;
    res_t       tval;
  } step_t;

  typedef struct {
    idx_t row;
    idx_t col;
    res_t value;
    logic last;
  } out_elem_t;

  logic clk = 1'b0;
  logic rst_n;

  smmas_in_if  in_ch ();
  smmas_out_if out_ch ();
  smmas_cfg_if cfg_ch ();

  small_matrix_multiply_add_sub dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  elem_t mat_a [64];
  elem_t mat_b [64];
  dim_t  dim_regs [4];

  out_elem_t computed_elems [$];
  out_elem_t pending_elems [$];

  int err_cnt = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  function automatic int unsigned eff_dim(dim_t d);
    return (d > MAX_DIM) ? MAX_DIM : d;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Update the matrix stores, or compute the result elements of a command.
  task automatic apply_cmd(op_t op, idx_t r, idx_t c, elem_t v);
    int unsigned ar, ac, br, bc, nr, nc;
    longint acc;
    out_elem_t e;
    ar = eff_dim(dim_regs[REG_A_ROWS]);
    ac = eff_dim(dim_regs[REG_A_COLS]);
    br = eff_dim(dim_regs[REG_B_ROWS]);
    bc = eff_dim(dim_regs[REG_B_COLS]);
    computed_elems.delete();
    if (op == OP_WR_A || op == OP_WR_B) begin
      if (r < MAX_DIM && c < MAX_DIM) begin
        if (op == OP_WR_A) mat_a[r * STRIDE + c] = v;
        else mat_b[r * STRIDE + c] = v;
      end
      return;
    end
    if (op == OP_MUL) begin
      if (ac != br) return;
      nr = ar;
      nc = bc;
    end else if (op == OP_ADD || op == OP_SUB) begin
      if (ar != br || ac != bc) return;
      nr = ar;
      nc = ac;
    end else begin
      return;
    end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        if (op == OP_MUL) begin
          for (int k = 0; k < ac; k++)
            acc += longint'(mat_a[i * STRIDE + k]) * longint'(mat_b[k * STRIDE + j]);
        end else if (op == OP_ADD) begin
          acc = (longint'(mat_a[i * STRIDE + j]) + longint'(mat_b[i * STRIDE + j])) * 256;
        end else begin
          acc = (longint'(mat_a[i * STRIDE + j]) - longint'(mat_b[i * STRIDE + j])) * 256;
        end
        e.row   = idx_t'(i);
        e.col   = idx_t'(j);
        e.value = res_t'(acc);
        e.last  = (i + 1 == nr) && (j + 1 == nc);
        computed_elems.push_back(e);
      end
    end
  endtask

  task automatic send_item(op_t op, idx_t r, idx_t c, elem_t v, check_t chk, res_t tv);
    out_elem_t e;
    @(negedge clk);
    if (src_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.row   <= r;
    in_ch.col   <= c;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_cmd(op, r, c, v);
    case (chk)
      CHK_PRED: begin
        foreach (computed_elems[i]) pending_elems.push_back(computed_elems[i]);
      end
      CHK_ONE: begin
        e.row   = '0;
        e.col   = '0;
        e.value = tv;
        e.last  = 1'b1;
        pending_elems.push_back(e);
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(reg_idx_t sel, dim_t d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    dim_regs[sel] = d;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Block is idle once every expected beat is in and the idle gap has passed.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  function automatic step_t cmd(op_t op, idx_t r, idx_t c, elem_t v, check_t chk, res_t tv);
    step_t s;
    s.kind  = ST_CMD;
    s.op    = op;
    s.row   = r;
    s.col   = c;
    s.value = v;
    s.sel   = REG_A_ROWS;
    s.data  = '0;
    s.chk   = chk;
    s.tval  = tv;
    return s;
  endfunction

  function automatic step_t regw(reg_idx_t sel, dim_t d);
    step_t s;
    s = cmd(OP_WR_A, 0, 0, 0, CHK_NONE, 0);
    s.kind = ST_REG;
    s.sel  = sel;
    s.data = d;
    return s;
  endfunction

  function automatic dim_t pick_dim();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 11) return dim_t'($urandom_range(1, 3));
    if (r < 14) return dim_t'($urandom_range(4, 7));
    if (r == 14) return dim_t'(MAX_DIM);
    return dim_t'($urandom_range(MAX_DIM + 1, 15));
  endfunction

  // result sink
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (sink_idle_on && !quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_out
    out_elem_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected beat row %0d col %0d value %0d",
                                  out_ch.out_row, out_ch.out_col, out_ch.result_value));
      end else begin
        want = pending_elems.pop_front();
        if (out_ch.out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_ch.out_row, want.row));
        if (out_ch.out_col !== want.col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_ch.out_col, want.col));
        if (out_ch.result_value !== want.value)
          report_mismatch($sformatf("result_value %0d at (%0d,%0d), want %0d",
                                    out_ch.result_value, want.row, want.col, want.value));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %b at (%0d,%0d), want %b",
                                    out_ch.last, want.row, want.col, want.last));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    step_t steps [$];
    step_t s;
    dim_t d [4];
    int unsigned lim, mode, r, waited;
    op_t op;
    elem_t v;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_WR_A;
    in_ch.row    = '0;
    in_ch.col    = '0;
    in_ch.value  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_A_ROWS;
    cfg_ch.data  = '0;
    foreach (mat_a[i]) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
    end
    foreach (dim_regs[i]) dim_regs[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    steps = '{
      // all dimensions zero after reset: nothing comes out
      cmd(OP_MUL, 0, 0, 0, CHK_NONE, 0),
      cmd(OP_SUB, 0, 0, 0, CHK_NONE, 0),
      regw(REG_A_ROWS, 1), regw(REG_A_COLS, 1), regw(REG_B_ROWS, 1), regw(REG_B_COLS, 1),
      cmd(OP_MUL, 3, 5, 0, CHK_ONE, 0),
      cmd(OP_WR_A, 0, 0, 32767, CHK_NONE, 0),
      cmd(OP_WR_B, 0, 0, 32767, CHK_NONE, 0),
      cmd(OP_MUL, 0, 0, 0, CHK_ONE, 1073676289),
      cmd(OP_ADD, 0, 0, 0, CHK_ONE, 16776704),
      cmd(OP_SUB, 0, 0, 0, CHK_ONE, 0),
      cmd(OP_WR_B, 0, 0, -32768, CHK_NONE, 0),
      cmd(OP_MUL, 0, 0, 0, CHK_ONE, -1073709056),
      cmd(OP_SUB, 0, 0, 0, CHK_ONE, 16776960),
      cmd(OP_WR_A, 0, 0, -32768, CHK_NONE, 0),
      cmd(OP_MUL, 7, 7, -1, CHK_ONE, 1073741824),
      cmd(OP_ADD, 0, 0, 0, CHK_ONE, -16777216),
      cmd(OP_UNUSED_LO, 0, 0, 0, CHK_NONE, 0),
      cmd(OP_UNUSED_HI, 7, 7, -1, CHK_NONE, 0),
      // element outside the used 1x1 window must not be read
      cmd(OP_WR_A, 7, 7, 12345, CHK_NONE, 0),
      cmd(OP_MUL, 0, 0, 0, CHK_ONE, 1073741824),
      // 15 clamps to the largest size
      regw(REG_A_ROWS, 8), regw(REG_A_COLS, 15), regw(REG_B_ROWS, 15), regw(REG_B_COLS, 8),
      cmd(OP_MUL, 0, 0, 0, CHK_PRED, 0),
      cmd(OP_SUB, 0, 0, 0, CHK_PRED, 0),
      regw(REG_A_ROWS, 2), regw(REG_A_COLS, 3), regw(REG_B_ROWS, 2), regw(REG_B_COLS, 3),
      cmd(OP_MUL, 0, 0, 0, CHK_NONE, 0),
      cmd(OP_ADD, 0, 0, 0, CHK_PRED, 0),
      regw(REG_B_ROWS, 3),
      cmd(OP_MUL, 0, 0, 0, CHK_PRED, 0),
      cmd(OP_ADD, 0, 0, 0, CHK_NONE, 0),
      regw(REG_A_ROWS, 0),
      cmd(OP_MUL, 0, 0, 0, CHK_NONE, 0)
    };

    foreach (steps[n]) begin
      s = steps[n];
      if (s.kind == ST_REG) begin
        wait_idle();
        write_reg(s.sel, s.data);
      end else begin
        send_item(s.op, s.row, s.col, s.value, s.chk, s.tval);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      quiet        = (ph >= NUM_PHASES - 3);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);

      d[0] = pick_dim();
      d[1] = pick_dim();
      d[2] = pick_dim();
      mode = $urandom_range(0, 3);
      if (ph == PRESS_PHASE) mode = 4;
      case (mode)
        0: d = '{d[0], d[0], d[0], d[0]};
        1: d = '{d[0], d[1], d[1], d[2]};
        2: d = '{d[0], d[1], d[0], d[1]};
        3: foreach (d[i]) d[i] = dim_t'($urandom_range(0, 15));
        default: d = '{3, 3, 3, 3};
      endcase
      write_reg(REG_A_ROWS, d[0]);
      write_reg(REG_A_COLS, d[1]);
      write_reg(REG_B_ROWS, d[2]);
      write_reg(REG_B_COLS, d[3]);

      // keep writes mostly inside the window in use
      lim = 1;
      foreach (d[i]) if (eff_dim(d[i]) > lim) lim = eff_dim(d[i]);
      if ($urandom_range(0, 3) == 0) lim = MAX_DIM;

      if (ph == PRESS_PHASE) hold_req = 1'b1;

      for (int it = 0; it < PHASE_ITEMS; it++) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          default: v = elem_t'($urandom_range(0, 65535));
        endcase
        if (ph == PRESS_PHASE && it == 0) op = OP_ADD;
        else if (r < 35) op = OP_WR_A;
        else if (r < 70) op = OP_WR_B;
        else if (r < 95) op = op_t'($urandom_range(OP_MUL, OP_SUB));
        else op = op_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        send_item(op, idx_t'($urandom_range(0, lim - 1)), idx_t'($urandom_range(0, lim - 1)),
                  v, CHK_PRED, 0);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_elems.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (IDLE_GAP) @(posedge clk);
    if (pending_elems.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", pending_elems.size()));

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/smmas_pkg.sv
rtl/smmas_if.sv
rtl/small_matrix_multiply_add_sub.sv
tb/sv/tb_top.sv
